// ===== src/pcfich_resource_element_mapper_assert.svh =====
// assertion macros for the pcfich resource element mapper
// expects clk and rst_n in the scope of use
`ifndef PCFICH_RESOURCE_ELEMENT_MAPPER_ASSERT_SVH
`define PCFICH_RESOURCE_ELEMENT_MAPPER_ASSERT_SVH

// same-cycle implication
`define PCFICH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCFICH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcfich_pkg.sv =====
// shared types, constants and helpers for the pcfich resource element mapper
// no dependencies
package pcfich_pkg;

  localparam int unsigned SC_PER_BLOCK = 12;
  localparam int unsigned MIN_BLOCKS   = 6;
  localparam int unsigned MAX_BLOCKS   = 110;

  localparam int unsigned CELL_W = 9;
  localparam int unsigned NB_W   = 7;
  localparam int unsigned M2_W   = NB_W + 1;
  localparam int unsigned SC_W   = 4;
  localparam int unsigned GRP_W  = 2;
  localparam int unsigned CIDX_W = 3;
  localparam int unsigned CDAT_W = 7;
  localparam int unsigned REM_STAGES = 3;
  localparam int unsigned DIV_W  = CELL_W + 4;

  localparam logic [GRP_W-1:0] GRP_LAST = 2'd3;

  typedef enum logic [CIDX_W-1:0] {
    CFG_NUM_BLOCKS = 3'd0,
    CFG_REF_POS_A  = 3'd1,
    CFG_REF_POS_B  = 3'd2,
    CFG_REF_POS_C  = 3'd3,
    CFG_REF_POS_D  = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [M2_W-1:0] rem;
    logic [NB_W-1:0] nb;
  } rem_item_t;

  function automatic logic [NB_W-1:0] nb_clamp(input logic [NB_W-1:0] nb);
    logic [NB_W-1:0] res;
    res = nb;
    if (nb < NB_W'(MIN_BLOCKS)) res = NB_W'(MIN_BLOCKS);
    if (nb > NB_W'(MAX_BLOCKS)) res = NB_W'(MAX_BLOCKS);
    return res;
  endfunction

  // one restoring step: subtract divisor shifted by sh when it fits
  function automatic logic [CELL_W-1:0] rem_step(input logic [CELL_W-1:0] rem,
                                                 input logic [M2_W-1:0] m2,
                                                 input logic [2:0] sh);
    logic [DIV_W-1:0] dsub;
    logic [CELL_W-1:0] res;
    dsub = DIV_W'(m2) << sh;
    res = rem;
    if (DIV_W'(rem) >= dsub) res = rem - dsub[CELL_W-1:0];
    return res;
  endfunction

  function automatic logic is_ref(input logic [SC_W-1:0] sc, input logic [SC_W-1:0] a,
                                  input logic [SC_W-1:0] b, input logic [SC_W-1:0] c,
                                  input logic [SC_W-1:0] d);
    return (sc == a) || (sc == b) || (sc == c) || (sc == d);
  endfunction

endpackage

// ===== src/pcfich_resource_element_mapper.sv =====
// Maps a physical cell identity onto the four PCFICH resource element groups.
// Each accepted cell identity gives up to four results in group order, one per
// cycle while out_ready is high; a missing reference position ends the run
// early with a fault result. The remainder pipeline takes new cell identities
// while earlier ones expand; the single result port bounds the sustained rate.
// First results pass an input register, three stages of a two-step restoring
// remainder unit, group expansion and the output register. Configuration writes
// are always taken (cfg_ready is tied high) and belong only to idle periods.
// depends on pcfich_pkg, pcfich_rem_pipe and the assertion macro header
`include "pcfich_resource_element_mapper_assert.svh"

module pcfich_resource_element_mapper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pcfich_pkg::CIDX_W-1:0]     cfg_index,
  input  logic [pcfich_pkg::CDAT_W-1:0]     cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcfich_pkg::CELL_W-1:0]     in_cell_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pcfich_pkg::GRP_W-1:0]      out_group_index,
  output logic [pcfich_pkg::NB_W-1:0]       out_block_index,
  output logic [pcfich_pkg::SC_W-1:0]       out_sub_first,
  output logic [pcfich_pkg::SC_W-1:0]       out_sub_second,
  output logic [pcfich_pkg::SC_W-1:0]       out_sub_third,
  output logic [pcfich_pkg::SC_W-1:0]       out_sub_fourth,
  output logic                              out_map_fault,
  output logic                              out_last_group
);
  import pcfich_pkg::*;

  logic [NB_W-1:0] num_blocks_r;
  logic [SC_W-1:0] ref_a_r, ref_b_r, ref_c_r, ref_d_r;

  logic       rp_valid, rp_ready;
  rem_item_t  rp_item;

  logic             ex_valid_r, ex_valid_nxt;
  logic [GRP_W-1:0] ex_grp_r, ex_grp_nxt;
  logic [M2_W-1:0]  ex_rem_r;
  logic [NB_W-1:0]  ex_nb_r;
  logic [M2_W-1:0]  ex_nb3h_r;

  logic out_valid_r, out_valid_nxt;
  logic [GRP_W-1:0] grp_out_r;
  logic [NB_W-1:0]  blk_out_r;
  logic [SC_W-1:0]  s0_out_r, s1_out_r, s2_out_r, s3_out_r;
  logic             fault_out_r, last_out_r;

  logic             out_adv, emit, ex_last, ex_free;
  logic [M2_W-1:0]  addend;
  logic [M2_W:0]    sum;
  logic [M2_W-1:0]  tpos;
  logic [SC_W-1:0]  sc;
  logic             hit0, hit1, hit2, fault;
  logic [SC_W-1:0]  s0, s1, s2, s3;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r <= NB_W'(50);
      ref_a_r      <= SC_W'(0);
      ref_b_r      <= SC_W'(3);
      ref_c_r      <= SC_W'(6);
      ref_d_r      <= SC_W'(9);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NUM_BLOCKS: num_blocks_r <= cfg_data[NB_W-1:0];
        CFG_REF_POS_A:  ref_a_r      <= cfg_data[SC_W-1:0];
        CFG_REF_POS_B:  ref_b_r      <= cfg_data[SC_W-1:0];
        CFG_REF_POS_C:  ref_c_r      <= cfg_data[SC_W-1:0];
        CFG_REF_POS_D:  ref_d_r      <= cfg_data[SC_W-1:0];
        default: ;
      endcase
    end
  end

  pcfich_rem_pipe u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cell   (in_cell_id),
    .in_nb     (nb_clamp(num_blocks_r)),
    .out_valid (rp_valid),
    .out_ready (rp_ready),
    .out_item  (rp_item)
  );

  // group expansion: offset in units of six subcarriers, modulo 2*nb
  always_comb begin
    case (ex_grp_r)
      2'd0:    addend = '0;
      2'd1:    addend = M2_W'(ex_nb_r >> 1);
      2'd2:    addend = M2_W'(ex_nb_r);
      default: addend = ex_nb3h_r;
    endcase
    sum  = (M2_W+1)'(ex_rem_r) + (M2_W+1)'(addend);
    tpos = (sum >= (M2_W+1)'({ex_nb_r, 1'b0})) ? M2_W'(sum - (M2_W+1)'({ex_nb_r, 1'b0}))
                                                : sum[M2_W-1:0];
    sc   = tpos[0] ? SC_W'(SC_PER_BLOCK / 2) : '0;
    hit0 = is_ref(sc, ref_a_r, ref_b_r, ref_c_r, ref_d_r);
    hit1 = is_ref(sc + SC_W'(1), ref_a_r, ref_b_r, ref_c_r, ref_d_r);
    hit2 = is_ref(sc + SC_W'(2), ref_a_r, ref_b_r, ref_c_r, ref_d_r);
    fault = 1'b0;
    s0 = '0;
    s1 = '0;
    s2 = '0;
    s3 = '0;
    if (hit0) begin
      s0 = sc + SC_W'(1); s1 = sc + SC_W'(2); s2 = sc + SC_W'(4); s3 = sc + SC_W'(5);
    end else if (hit1) begin
      s0 = sc;            s1 = sc + SC_W'(2); s2 = sc + SC_W'(3); s3 = sc + SC_W'(5);
    end else if (hit2) begin
      s0 = sc;            s1 = sc + SC_W'(1); s2 = sc + SC_W'(3); s3 = sc + SC_W'(4);
    end else begin
      fault = 1'b1;
    end
  end

  assign out_adv  = !out_valid_r || out_ready;
  assign emit     = ex_valid_r && out_adv;
  assign ex_last  = fault || (ex_grp_r == GRP_LAST);
  assign ex_free  = !ex_valid_r || (emit && ex_last);
  assign rp_ready = ex_free;

  always_comb begin
    ex_valid_nxt = ex_valid_r;
    ex_grp_nxt   = ex_grp_r;
    if (ex_free) begin
      ex_valid_nxt = rp_valid;
      ex_grp_nxt   = '0;
    end else if (emit) begin
      ex_grp_nxt = ex_grp_r + GRP_W'(1);
    end
    out_valid_nxt = out_adv ? emit : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      ex_grp_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      ex_grp_r    <= ex_grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_free) begin
      ex_rem_r  <= rp_item.rem;
      ex_nb_r   <= rp_item.nb;
      ex_nb3h_r <= M2_W'(rp_item.nb) + M2_W'(rp_item.nb >> 1);
    end
    if (emit) begin
      grp_out_r   <= ex_grp_r;
      blk_out_r   <= tpos[M2_W-1:1];
      s0_out_r    <= s0;
      s1_out_r    <= s1;
      s2_out_r    <= s2;
      s3_out_r    <= s3;
      fault_out_r <= fault;
      last_out_r  <= ex_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_group_index = grp_out_r;
  assign out_block_index = blk_out_r;
  assign out_sub_first   = s0_out_r;
  assign out_sub_second  = s1_out_r;
  assign out_sub_third   = s2_out_r;
  assign out_sub_fourth  = s3_out_r;
  assign out_map_fault   = fault_out_r;
  assign out_last_group  = last_out_r;

  `PCFICH_ASSERT_NOW(a_fault_ends_run, out_valid && out_map_fault, out_last_group, "fault result not marked last")
  `PCFICH_ASSERT_NOW(a_fault_zero_subs, out_valid && out_map_fault, (out_sub_first == '0) && (out_sub_second == '0) && (out_sub_third == '0) && (out_sub_fourth == '0), "fault result carries subcarriers")
  `PCFICH_ASSERT_NOW(a_group3_last, out_valid && (out_group_index == GRP_LAST), out_last_group, "fourth group not marked last")
  `PCFICH_ASSERT_NEXT(a_run_continues, emit && !ex_last, ex_valid_r && (ex_grp_r == $past(ex_grp_r) + GRP_W'(1)), "group run dropped early")

endmodule

// ===== src/pcfich_rem_pipe.sv =====
// pipelined remainder of cell identity modulo twice the block count
// two restoring steps per stage; depends on pcfich_pkg
module pcfich_rem_pipe (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pcfich_pkg::CELL_W-1:0]     in_cell,
  input  logic [pcfich_pkg::NB_W-1:0]       in_nb,
  output logic                              out_valid,
  input  logic                              out_ready,
  output pcfich_pkg::rem_item_t             out_item
);
  import pcfich_pkg::*;

  logic                  v_r    [REM_STAGES+1];
  logic [CELL_W-1:0]     rem_r  [REM_STAGES+1];
  logic [NB_W-1:0]       nb_r   [REM_STAGES+1];
  logic                  free   [REM_STAGES+1];

  always_comb begin
    free[REM_STAGES] = !v_r[REM_STAGES] || out_ready;
    for (int s = REM_STAGES - 1; s >= 0; s--) begin
      free[s] = !v_r[s] || free[s+1];
    end
  end

  assign in_ready      = free[0];
  assign out_valid     = v_r[REM_STAGES];
  assign out_item.rem  = rem_r[REM_STAGES][M2_W-1:0];
  assign out_item.nb   = nb_r[REM_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= REM_STAGES; s++) begin
        v_r[s] <= 1'b0;
      end
    end else begin
      if (free[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s <= REM_STAGES; s++) begin
        if (free[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free[0]) begin
      rem_r[0] <= in_cell;
      nb_r[0]  <= in_nb;
    end
    for (int s = 1; s <= REM_STAGES; s++) begin
      if (free[s]) begin
        rem_r[s] <= rem_step(rem_step(rem_r[s-1], {nb_r[s-1], 1'b0}, 3'(2 * (REM_STAGES - s) + 1)),
                             {nb_r[s-1], 1'b0}, 3'(2 * (REM_STAGES - s)));
        nb_r[s]  <= nb_r[s-1];
      end
    end
  end

endmodule
